/* rtl/core/shpp_pkg.sv */
// Shared constants for the shadow probability core.
`timescale 1ns / 1ps
package shpp_pkg;

   localparam int DENS_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int EXP_WIDTH = 33;
   localparam int FRAC_WIDTH = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHADOW_MEAN = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_TWO_VAR = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PDF_NORM = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNIFORM_DENSITY = 8'd3;

   localparam logic [DENS_WIDTH-1:0] INV_TWO_VAR_RESET = 24'd65536;
   localparam logic [DENS_WIDTH-1:0] PDF_NORM_RESET = 24'd26145;
   localparam logic [DENS_WIDTH-1:0] UNIFORM_DENSITY_RESET = 24'd655;

   // exp(-1/16) in Q0.32, summed from its series at 2^60 scale. Each term is the
   // previous one over 16n, truncated; the tenth term is the last one summed.
   localparam logic [63:0] EXP_T0 = 64'd1 << 60;
   localparam logic [63:0] EXP_T1 = EXP_T0 / 64'd16;
   localparam logic [63:0] EXP_T2 = EXP_T1 / 64'd32;
   localparam logic [63:0] EXP_T3 = EXP_T2 / 64'd48;
   localparam logic [63:0] EXP_T4 = EXP_T3 / 64'd64;
   localparam logic [63:0] EXP_T5 = EXP_T4 / 64'd80;
   localparam logic [63:0] EXP_T6 = EXP_T5 / 64'd96;
   localparam logic [63:0] EXP_T7 = EXP_T6 / 64'd112;
   localparam logic [63:0] EXP_T8 = EXP_T7 / 64'd128;
   localparam logic [63:0] EXP_T9 = EXP_T8 / 64'd144;
   localparam logic [63:0] EXP_SUM = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                   - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9;
   localparam logic [63:0] EXP_RATIO = (EXP_SUM + (64'd1 << 27)) >> 28;

endpackage

/* rtl/core/shpp_arg.sv */
// Distance, square and scaled exponent argument stages.
`timescale 1ns / 1ps
module shpp_arg #(
   parameter int RADIANCE_WIDTH = 16,
   parameter int EXP_TABLE_DEPTH = 256,
   parameter int IDX_WIDTH = 9
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [RADIANCE_WIDTH-1:0]            radiance,
   input  logic [RADIANCE_WIDTH-1:0]            shadow_mean,
   input  logic [shpp_pkg::DENS_WIDTH-1:0]      inv_two_var,
   output logic                                 out_valid,
   output logic [IDX_WIDTH-1:0]                 idx,
   output logic [shpp_pkg::FRAC_WIDTH-1:0]      frac,
   output logic                                 far
);
   import shpp_pkg::*;

   logic [3:0]                  v_ff, v_in;
   logic [RADIANCE_WIDTH-1:0]   ad_ff, ad_in;
   logic [2*RADIANCE_WIDTH-1:0] d2_ff, d2_in;
   logic [63:0]                 d2w;
   logic [43:0]                 plo_ff, plo_in, phi_ff, phi_in;
   logic                        hinz_ff, hinz_in;
   logic [63:0]                 full;
   logic                        far_in, far_ff;
   logic [IDX_WIDTH-1:0]        idx_ff, idx_in;
   logic [FRAC_WIDTH-1:0]       frac_ff, frac_in;

   always_comb begin
      v_in = {v_ff[2:0], in_valid};
      ad_in = (radiance >= shadow_mean) ? radiance - shadow_mean : shadow_mean - radiance;
      d2_in = (2*RADIANCE_WIDTH)'(ad_ff) * (2*RADIANCE_WIDTH)'(ad_ff);
      d2w = 64'(d2_ff);
      plo_in = 44'(d2w[19:0]) * 44'(inv_two_var);
      phi_in = 44'(d2w[39:20]) * 44'(inv_two_var);
      hinz_in = (d2w[63:40] != 24'd0) && (inv_two_var != 24'd0);
      full = 64'(plo_ff) + (64'(phi_ff) << 20);
      far_in = hinz_ff || ((full >> 28) >= 64'(EXP_TABLE_DEPTH));
      idx_in = far_in ? '0 : IDX_WIDTH'(full >> 28);
      frac_in = full[27:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         ad_ff <= ad_in;
         d2_ff <= d2_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         hinz_ff <= hinz_in;
         far_ff <= far_in;
         idx_ff <= idx_in;
         frac_ff <= frac_in;
      end
   end

   assign out_valid = v_ff[3];
   assign idx = idx_ff;
   assign frac = frac_ff;
   assign far = far_ff;
endmodule

/* rtl/core/shpp_exp.sv */
// Exponential table lookup, interpolation and gaussian scaling stages.
`timescale 1ns / 1ps
module shpp_exp #(
   parameter int EXP_TABLE_DEPTH = 256,
   parameter int IDX_WIDTH = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [IDX_WIDTH-1:0]            idx,
   input  logic [shpp_pkg::FRAC_WIDTH-1:0] frac,
   input  logic                            far,
   input  logic [shpp_pkg::DENS_WIDTH-1:0] pdf_norm,
   output logic                            out_valid,
   output logic [56:0]                     dens_prod
);
   import shpp_pkg::*;

   typedef logic [EXP_WIDTH-1:0] etab_type [EXP_TABLE_DEPTH+1];

   function automatic etab_type build_etab();
      etab_type t;
      logic [63:0] r;
      logic [63:0] acc;
      r = EXP_RATIO;
      acc = 64'd1 << 32;
      for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
         t[k] = EXP_WIDTH'(acc);
         acc = (acc * r + (64'd1 << 31)) >> 32;
      end
      return t;
   endfunction

   localparam etab_type ETAB = build_etab();

   logic [3:0]            v_ff, v_in;
   logic [EXP_WIDTH-1:0]  a_ff, b_ff, a2_ff, e_ff, e_in;
   logic [FRAC_WIDTH-1:0] frac_ff;
   logic                  far_ff, far2_ff;
   logic [44:0]           dp_ff, dp_in;
   logic [56:0]           prod_ff, prod_in;
   logic [44:0]           rnd;

   always_comb begin
      v_in = {v_ff[2:0], in_valid};
      dp_in = 45'(a_ff - b_ff) * 45'(frac_ff);
      rnd = (dp_ff + 45'd2048) >> 12;
      e_in = far2_ff ? '0 : a2_ff - EXP_WIDTH'(rnd);
      prod_in = 57'(pdf_norm) * 57'(e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         a_ff <= ETAB[idx];
         b_ff <= ETAB[idx + IDX_WIDTH'(1)];
         frac_ff <= frac;
         far_ff <= far;
         dp_ff <= dp_in;
         a2_ff <= a_ff;
         far2_ff <= far_ff;
         e_ff <= e_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = v_ff[3];
   assign dens_prod = prod_ff;
endmodule

/* rtl/core/shpp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the posterior.
`timescale 1ns / 1ps
module shpp_div #(
   parameter int PROB_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [shpp_pkg::DENS_WIDTH-1:0] dens,
   input  logic [shpp_pkg::DENS_WIDTH:0]   den,
   output logic                            out_valid,
   output logic [shpp_pkg::DENS_WIDTH-1:0] out_dens,
   output logic                            out_zero,
   output logic [PROB_WIDTH:0]             quot
);
   import shpp_pkg::*;

   localparam int NW = DENS_WIDTH + PROB_WIDTH + 1;
   localparam int ST = PROB_WIDTH + 1;

   logic [NW-1:0]          num;
   logic [ST:0]            v_ff;
   logic [DENS_WIDTH+1:0]  r_ff [ST+1];
   logic [PROB_WIDTH:0]    l_ff [ST+1];
   logic [PROB_WIDTH:0]    q_ff [ST+1];
   logic [DENS_WIDTH:0]    den_ff [ST+1];
   logic [DENS_WIDTH-1:0]  dens_ff [ST+1];
   logic                   z_ff [ST+1];

   assign num = (NW'(dens) << PROB_WIDTH) + NW'(den >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ST-1:0], in_valid};
      end
      if (en) begin
         r_ff[0] <= (DENS_WIDTH+2)'(num[NW-1:PROB_WIDTH+1]);
         l_ff[0] <= num[PROB_WIDTH:0];
         q_ff[0] <= '0;
         den_ff[0] <= den;
         dens_ff[0] <= dens;
         z_ff[0] <= (den == '0);
      end
   end

   for (genvar s = 0; s < ST; s++) begin : g_step
      logic [DENS_WIDTH+1:0] t;
      logic                  ge;
      assign t = {r_ff[s][DENS_WIDTH:0], l_ff[s][PROB_WIDTH]};
      assign ge = t >= (DENS_WIDTH+2)'(den_ff[s]);
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s+1] <= ge ? t - (DENS_WIDTH+2)'(den_ff[s]) : t;
            l_ff[s+1] <= {l_ff[s][PROB_WIDTH-1:0], 1'b0};
            q_ff[s+1] <= {q_ff[s][PROB_WIDTH-1:0], ge};
            den_ff[s+1] <= den_ff[s];
            dens_ff[s+1] <= dens_ff[s];
            z_ff[s+1] <= z_ff[s];
         end
      end
   end

   assign out_valid = v_ff[ST];
   assign out_dens = dens_ff[ST];
   assign out_zero = z_ff[ST];
   assign quot = q_ff[ST];
endmodule

/* rtl/core/shadow_probability_per_pixel_core.sv */
// Top level of the per-pixel shadow posterior probability pipeline.
`timescale 1ns / 1ps
// Usage: radiance pixels arrive as beats on the req_ channel (valid/ready) and one
// result beat per pixel leaves on the rsp_ channel, carrying the gaussian shadow
// density (Q8.16, saturating) and the posterior probability (Q0.PROB_WIDTH).
// The four statistics registers are written on the csr_ channel, which is always
// ready; index 0 is the shadow mean, 1 the inverse twice variance, 2 the pdf
// normalizer and 3 the uniform density. Other indexes are ignored. Write them only
// while no pixel is in flight.
// Throughput is one pixel per cycle while the receiver keeps up. The pipeline holds
// four argument stages, four table and scaling stages, one
// rounding stage, PROB_WIDTH + 2 divider stages (an input register and one per
// quotient bit) and the output register. The divider, which retires one quotient
// bit per stage, sets the depth.
// Reset clears every valid bit and loads the register reset values; the
// exponential table is a constant and needs no fill. When the receiver stalls,
// the whole pipeline holds in place and req_ready drops, so nothing is lost.
module shadow_probability_per_pixel_core #(
   parameter int RADIANCE_WIDTH = 16,
   parameter int PROB_WIDTH = 16,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [RADIANCE_WIDTH-1:0]             req_radiance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [shpp_pkg::DENS_WIDTH-1:0]       rsp_shadow_density,
   output logic [PROB_WIDTH-1:0]                 rsp_shadow_prob,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [shpp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [shpp_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import shpp_pkg::*;

   localparam int IDX_WIDTH = $clog2(EXP_TABLE_DEPTH + 1);
   localparam logic [PROB_WIDTH:0] PROB_MAX = {1'b0, {PROB_WIDTH{1'b1}}};

   // Statistics registers.
   logic [RADIANCE_WIDTH-1:0] mean_ff;
   logic [DENS_WIDTH-1:0]     inv_ff, pdf_ff, uni_ff;

   // The whole pipeline advances together unless the output beat is stuck.
   logic en;
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         inv_ff <= INV_TWO_VAR_RESET;
         pdf_ff <= PDF_NORM_RESET;
         uni_ff <= UNIFORM_DENSITY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SHADOW_MEAN: mean_ff <= csr_data[RADIANCE_WIDTH-1:0];
            CSR_INV_TWO_VAR: inv_ff <= csr_data[DENS_WIDTH-1:0];
            CSR_PDF_NORM: pdf_ff <= csr_data[DENS_WIDTH-1:0];
            CSR_UNIFORM_DENSITY: uni_ff <= csr_data[DENS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic                  arg_valid;
   logic [IDX_WIDTH-1:0]  arg_idx;
   logic [FRAC_WIDTH-1:0] arg_frac;
   logic                  arg_far;

   shpp_arg #(
      .RADIANCE_WIDTH(RADIANCE_WIDTH),
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
      .IDX_WIDTH(IDX_WIDTH)
   ) u_arg (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid && req_ready), .radiance(req_radiance),
      .shadow_mean(mean_ff), .inv_two_var(inv_ff),
      .out_valid(arg_valid), .idx(arg_idx), .frac(arg_frac), .far(arg_far)
   );

   logic        exp_valid;
   logic [56:0] exp_prod;

   shpp_exp #(
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
      .IDX_WIDTH(IDX_WIDTH)
   ) u_exp (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(arg_valid), .idx(arg_idx), .frac(arg_frac), .far(arg_far),
      .pdf_norm(pdf_ff), .out_valid(exp_valid), .dens_prod(exp_prod)
   );

   // Round the density product back to Q8.16, saturate, and form the denominator.
   logic [57:0]           dens_round;
   logic [DENS_WIDTH-1:0] dens_in, dens_ff;
   logic [DENS_WIDTH:0]   den_ff;
   logic                  rnd_valid_ff;

   assign dens_round = (58'(exp_prod) + (58'd1 << 31)) >> 32;
   assign dens_in = (dens_round > 58'(24'hFFFFFF)) ? 24'hFFFFFF : dens_round[DENS_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (en) begin
         rnd_valid_ff <= exp_valid;
      end
      if (en) begin
         dens_ff <= dens_in;
         den_ff <= (DENS_WIDTH+1)'(dens_in) + (DENS_WIDTH+1)'(uni_ff);
      end
   end

   logic                  div_valid, div_zero;
   logic [DENS_WIDTH-1:0] div_dens;
   logic [PROB_WIDTH:0]   div_quot;

   shpp_div #(.PROB_WIDTH(PROB_WIDTH)) u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(rnd_valid_ff), .dens(dens_ff), .den(den_ff),
      .out_valid(div_valid), .out_dens(div_dens), .out_zero(div_zero), .quot(div_quot)
   );

   // Output register: saturate the quotient, zero it when both terms were zero.
   logic                  rsp_valid_ff;
   logic [DENS_WIDTH-1:0] rsp_dens_ff;
   logic [PROB_WIDTH-1:0] rsp_prob_ff, prob_in;

   always_comb begin
      if (div_zero) prob_in = '0;
      else if (div_quot > PROB_MAX) prob_in = PROB_MAX[PROB_WIDTH-1:0];
      else prob_in = div_quot[PROB_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
      if (en) begin
         rsp_dens_ff <= div_dens;
         rsp_prob_ff <= prob_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_shadow_density = rsp_dens_ff;
   assign rsp_shadow_prob = rsp_prob_ff;

   // A zero likelihood can never yield a nonzero posterior.
   a_zero_dens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shadow_density == '0 |-> rsp_shadow_prob == '0)
      else $error("nonzero probability for zero density");

   // With no uniform term, any nonzero likelihood is full probability.
   a_no_uniform: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && uni_ff == '0 && rsp_shadow_density != '0
      |-> rsp_shadow_prob == PROB_MAX[PROB_WIDTH-1:0])
      else $error("probability not saturated without uniform term");

   // No result beat may appear right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat straight after reset");
endmodule

/* dv/shadow_probability_per_pixel_core_tb.sv */
// Self-checking testbench for the per-pixel shadow posterior probability core.
`timescale 1ns / 1ps
module shadow_probability_per_pixel_core_tb;
   import shpp_pkg::*;

   localparam int RAD_W = 16;
   localparam int PROB_W = 16;
   localparam int EXP_DEPTH = 256;
   localparam int PIPE_LATENCY = PROB_W + 12;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [RAD_W-1:0] req_radiance;
   logic rsp_valid;
   logic rsp_ready;
   logic [DENS_WIDTH-1:0] rsp_shadow_density;
   logic [PROB_W-1:0] rsp_shadow_prob;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   shadow_probability_per_pixel_core #(
      .RADIANCE_WIDTH(RAD_W),
      .PROB_WIDTH(PROB_W),
      .EXP_TABLE_DEPTH(EXP_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_radiance(req_radiance),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_shadow_density(rsp_shadow_density),
      .rsp_shadow_prob(rsp_shadow_prob),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   typedef struct packed {
      logic [DENS_WIDTH-1:0] density;
      logic [PROB_W-1:0] prob;
   } pixel_result_t;

   // Statistics as the predictor believes the block holds them.
   logic [RAD_W-1:0] mean_model;
   logic [23:0] inv_two_var_model;
   logic [23:0] pdf_norm_model;
   logic [23:0] uniform_model;
   logic [63:0] exp_table [0:EXP_DEPTH];

   logic [RAD_W-1:0] pixel_queue[$];
   pixel_result_t expected_results[$];

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_sender;
   bit stimulus_done;
   int error_count;
   int pixels_sent;
   int results_checked;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The table is built independently, from the exp(-1/16) series at 2^60 scale.
   initial begin : build_exp_table
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] ratio;
      logic [63:0] n;
      term = 64'd1 << 60;
      sum = 64'd0;
      n = 64'd0;
      while (term != 64'd0) begin
         if (n[0] == 1'b0) sum = sum + term;
         else sum = sum - term;
         n = n + 64'd1;
         term = term / (64'd16 * n);
      end
      ratio = (sum + (64'd1 << 27)) >> 28;
      exp_table[0] = 64'd1 << 32;
      for (int k = 1; k <= EXP_DEPTH; k++)
         exp_table[k] = (exp_table[k-1] * ratio + (64'd1 << 31)) >> 32;
   end

   // Gaussian likelihood against a uniform alternative, bit for bit.
   function automatic pixel_result_t shadow_posterior(logic [RAD_W-1:0] radiance);
      pixel_result_t r;
      logic [63:0] distance;
      logic [63:0] dist_sq;
      logic [63:0] arg;
      logic [63:0] idx;
      logic [63:0] frac;
      logic [63:0] e;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] dens;
      logic [63:0] denom;
      logic [63:0] prob;
      e = 64'd0;
      distance = (radiance >= mean_model) ? 64'(radiance - mean_model)
                                          : 64'(mean_model - radiance);
      dist_sq = distance * distance;
      if (inv_two_var_model == 24'd0) begin
         e = exp_table[0];
      end else if ((dist_sq >> 40) == 64'd0) begin
         arg = (dist_sq * 64'(inv_two_var_model)) >> 16;
         idx = arg >> 12;
         frac = arg & 64'd4095;
         if (idx < EXP_DEPTH) begin
            lo = exp_table[idx];
            hi = exp_table[idx + 1];
            e = lo - (((lo - hi) * frac + 64'd2048) >> 12);
         end
      end
      dens = (64'(pdf_norm_model) * e + (64'd1 << 31)) >> 32;
      if (dens > 64'hFFFFFF) dens = 64'hFFFFFF;
      denom = dens + 64'(uniform_model);
      if (denom == 64'd0) begin
         prob = 64'd0;
      end else begin
         prob = ((dens << PROB_W) + (denom >> 1)) / denom;
         if (prob > ((64'd1 << PROB_W) - 1)) prob = (64'd1 << PROB_W) - 1;
      end
      r.density = dens[DENS_WIDTH-1:0];
      r.prob = prob[PROB_W-1:0];
      return r;
   endfunction

   // Driver: pulls pixels from the queue, keeps valid and data steady until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_radiance <= '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(shadow_posterior(req_radiance));
            pixels_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_radiance <= pixel_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      pixel_result_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat density=%0d prob=%0d", $time,
                        rsp_shadow_density, rsp_shadow_prob);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_shadow_density !== want.density) begin
                  $display("%0t: density mismatch expected %0d actual %0d", $time,
                           want.density, rsp_shadow_density);
                  error_count++;
               end
               if (rsp_shadow_prob !== want.prob) begin
                  $display("%0t: prob mismatch expected %0d actual %0d", $time,
                           want.prob, rsp_shadow_prob);
                  error_count++;
               end
               results_checked++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL shadow_probability_per_pixel_core");
         $finish;
      end
   end

   // Waits for the pipeline to drain, then the full latency, so a write is safe.
   task automatic wait_drained();
      while (pixel_queue.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Writes one statistics register; the predictor follows at the same beat.
   // Valid drops for one cycle afterwards, so writes never overlap.
   task automatic write_stat(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SHADOW_MEAN: mean_model = value[RAD_W-1:0];
         CSR_INV_TWO_VAR: inv_two_var_model = value[23:0];
         CSR_PDF_NORM: pdf_norm_model = value[23:0];
         CSR_UNIFORM_DENSITY: uniform_model = value[23:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] m, logic [31:0] v, logic [31:0] p,
                            logic [31:0] u);
      write_stat(CSR_SHADOW_MEAN, m);
      write_stat(CSR_INV_TWO_VAR, v);
      write_stat(CSR_PDF_NORM, p);
      write_stat(CSR_UNIFORM_DENSITY, u);
   endtask

   // Mostly pixels near the mean so the table path gets exercised, some anywhere.
   task automatic queue_random_pixels(int count);
      int offs;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) != 0) begin
            offs = $urandom_range(2047) - 1024;
            pixel_queue.push_back(RAD_W'(int'(mean_model) + offs));
         end else begin
            pixel_queue.push_back(RAD_W'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_radiance = '0;
      rsp_ready = 1'b0;
      hold_sender = 1'b0;
      error_count = 0;
      pixels_sent = 0;
      results_checked = 0;
      cycle_count = 0;
      send_idle_pct = 14;
      recv_idle_pct = 86;
      mean_model = '0;
      inv_two_var_model = INV_TWO_VAR_RESET;
      pdf_norm_model = PDF_NORM_RESET;
      uniform_model = UNIFORM_DENSITY_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on reset values: field extremes and the table boundary.
      pixel_queue.push_back(16'h0000);
      pixel_queue.push_back(16'hFFFF);
      pixel_queue.push_back(16'h0001);
      pixel_queue.push_back(16'h8000);
      pixel_queue.push_back(16'h7FFF);
      pixel_queue.push_back(16'd1024);
      pixel_queue.push_back(16'd1023);
      pixel_queue.push_back(16'd1025);
      pixel_queue.push_back(16'd512);
      pixel_queue.push_back(16'hAAAA);
      pixel_queue.push_back(16'h5555);
      wait_drained();

      // Zero variance term gives the unscaled normalizer; huge normalizer saturates.
      write_all(32'h8000, 32'd0, 32'hFFFFFF, 32'd0);
      pixel_queue.push_back(16'h0000);
      pixel_queue.push_back(16'hFFFF);
      wait_drained();
      // Both terms zero, and excess bits in the data masked off.
      write_all(32'hFFFF_0000, 32'hFF00_0001, 32'h0100_0000, 32'hFF00_0000);
      pixel_queue.push_back(16'hFFFF);
      pixel_queue.push_back(16'h0000);
      pixel_queue.push_back(16'h0100);
      wait_drained();
      // Unknown index is ignored; maximum inverse variance.
      write_stat(8'd4, 32'h1234);
      write_stat(8'hFF, 32'hFFFF);
      write_all(32'hFFFF, 32'hFFFFFF, 32'd26145, 32'hFFFFFF);
      pixel_queue.push_back(16'hFFFF);
      pixel_queue.push_back(16'hFFFE);
      pixel_queue.push_back(16'h0000);
      pixel_queue.push_back(16'hFFFD);
      wait_drained();

      // Random phases, with the idle mix changing by phase.
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 86;
            recv_idle_pct = 14;
         end else if (phase == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase % 4)
            0: write_all($urandom, $urandom_range(16'hFFFF), $urandom, $urandom);
            1: write_all($urandom, $urandom_range(2048), $urandom_range(70000),
                         $urandom_range(2000));
            2: write_all($urandom, $urandom_range(64, 1), 32'hFFFFFF,
                         $urandom_range(3));
            default: write_all($urandom, 32'h10000 + $urandom_range(255),
                               $urandom_range(26145 * 4), 32'd655);
         endcase
         queue_random_pixels(42);
         // Sender pauses until everything outstanding has come back.
         while (pixel_queue.size() > 0 || req_valid) @(posedge clock);
         hold_sender = 1'b1;
         while (expected_results.size() > 0) @(posedge clock);
         hold_sender = 1'b0;
         queue_random_pixels(41);
         wait_drained();
      end

      $display("Covered %0d pixels and %0d checked results across 16 register settings,",
               pixels_sent, results_checked);
      $display("including zero variance, saturation, out-of-table and zero-sum cases.");
      if (error_count == 0) begin
         $display("PASS shadow_probability_per_pixel_core");
      end else begin
         $display("FAIL shadow_probability_per_pixel_core");
      end
      $finish;
   end

endmodule

/* shadow_probability_per_pixel_core.f */
rtl/core/shpp_pkg.sv
rtl/core/shpp_arg.sv
rtl/core/shpp_exp.sv
rtl/core/shpp_div.sv
rtl/core/shadow_probability_per_pixel_core.sv
dv/shadow_probability_per_pixel_core_tb.sv
